/* hdl/tcpt_pkg.sv */
package tcpt_pkg;

  // position scale, hundredths of a percent
  localparam int unsigned PosW     = 14;
  localparam logic [PosW-1:0] PosMax = 14'd10000;

  // serial divider geometry: 14 bit span magnitude times 32 bit run time
  localparam int unsigned ElapsedW  = 32;
  localparam int unsigned DividendW = PosW + ElapsedW;
  localparam int unsigned DivisorW  = 16;
  localparam int unsigned DivCntW   = $clog2(DividendW);

  // register defaults
  localparam logic [15:0] FullTravelRst = 16'd20000;
  localparam logic [15:0] OvershootRst  = 16'd2000;
  localparam logic [11:0] IntervalRst   = 12'd200;
  localparam logic        ActiveLowRst  = 1'b1;

  typedef enum logic [1:0] {
    OpMove = 2'd0,
    OpStop = 2'd1,
    OpTick = 2'd2,
    OpNone = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MotionStop = 2'd0,
    MotionUp   = 2'd1,
    MotionDown = 2'd2
  } motion_e;

  typedef enum logic [1:0] {
    RegFullTravel = 2'd0,
    RegOvershoot  = 2'd1,
    RegInterval   = 2'd2,
    RegActiveLow  = 2'd3
  } reg_idx_e;

endpackage

/* hdl/tcpt_div.sv */
module tcpt_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [tcpt_pkg::DividendW-1:0]      dividend_i,
  input  logic [tcpt_pkg::DivisorW-1:0]       divisor_i,
  output logic                                done_o,
  output logic [tcpt_pkg::DividendW-1:0]      quotient_o
);
  import tcpt_pkg::*;

  logic [DivisorW-1:0]  rem_q, rem_d;
  logic [DividendW-1:0] quo_q, quo_d;
  logic [DivisorW-1:0]  dsr_q;
  logic [DivCntW-1:0]   cnt_q;
  logic                 busy_q, done_q;
  logic [DivisorW:0]    trial;
  logic [DivisorW:0]    diff;
  logic                 fits;

  // one quotient bit per cycle, restoring
  assign trial = {rem_q, quo_q[DividendW-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign fits  = trial >= {1'b0, dsr_q};

  always_comb begin
    rem_d = fits ? diff[DivisorW-1:0] : trial[DivisorW-1:0];
    quo_d = {quo_q[DividendW-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DividendW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* hdl/timed_cover_position_tracker_unit.sv */
// move, stop and idle items give their result in the cycle after the transfer
// a tick while moving runs the multiply step, the divide steps, the divider's done pulse and the finish step
// throughput: one item at a time, set by the bit-serial divider of the interpolation
// reset: asynchronous active low, registers to their defaults, shade stopped and open
// reset: no clearing pass, the block is ready as soon as reset is released
module timed_cover_position_tracker_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [15:0]                   cfg_data_i,
  // command channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    operation_i,
  input  logic [tcpt_pkg::PosW-1:0]     target_position_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tcpt_pkg::PosW-1:0]     position_o,
  output logic                          position_updated_o,
  output logic                          relay_up_o,
  output logic                          relay_down_o,
  output logic [1:0]                    motion_state_o
);
  import tcpt_pkg::*;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StMul  = 4'b0010,
    StDiv  = 4'b0100,
    StFin  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [15:0] full_travel_q, overshoot_q;
  logic [11:0] interval_q;
  logic        active_low_q;

  // tracker state
  logic                moving_q;
  motion_e             dir_q;
  logic [PosW-1:0]     start_q, goal_q, reported_q;
  logic                endstop_q;
  logic [ElapsedW-1:0] elapsed_q;

  // result register
  logic            out_valid_q;
  logic [PosW-1:0] out_pos_q;
  logic            out_upd_q;
  motion_e         out_motion_q;

  logic            in_xfer, out_free;
  op_e             op;
  logic [PosW-1:0] tgt_sat;
  logic [ElapsedW:0] elapsed_sum;
  logic [ElapsedW-1:0] elapsed_next;

  // interpolation datapath
  logic                   opening;
  logic [PosW-1:0]        span_mag;
  logic [DividendW-1:0]   product;
  logic [DivisorW-1:0]    span;
  logic                   div_start, div_done;
  logic [DividendW-1:0]   quotient;
  logic signed [DividendW+1:0] est;
  logic signed [DividendW+1:0] start_s, goal_s, quo_s;
  logic                   reached;
  logic [DivisorW:0]      budget;
  logic                   halt;
  logic [PosW-1:0]        est_clamped, new_pos;

  assign cfg_ready_o = 1'b1;
  assign op          = op_e'(operation_i);
  // a result slot is free when empty or being emptied this cycle
  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == StIdle) && out_free;
  assign in_xfer     = in_valid_i && in_ready_o;

  // targets past the closed end saturate and so become an end stop
  assign tgt_sat = (target_position_i > PosMax) ? PosMax : target_position_i;

  // elapsed run time saturates at the counter's top value
  assign elapsed_sum  = {1'b0, elapsed_q} + {{(ElapsedW - 12 + 1){1'b0}}, interval_q};
  assign elapsed_next = elapsed_sum[ElapsedW] ? '1 : elapsed_sum[ElapsedW-1:0];

  // |goal - start| * elapsed feeds the divider straight from the multiplier
  assign opening  = goal_q < start_q;
  assign span_mag = opening ? (start_q - goal_q) : (goal_q - start_q);
  assign product  = {{ElapsedW{1'b0}}, span_mag} * {{PosW{1'b0}}, elapsed_q};
  assign span     = (full_travel_q == '0) ? DivisorW'(1) : full_travel_q;
  assign div_start = (state_q == StMul);

  tcpt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (product),
    .divisor_i  (span),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // truncation toward zero falls out of dividing the magnitude
  always_comb begin
    start_s = $signed({{(DividendW + 2 - PosW){1'b0}}, start_q});
    goal_s  = $signed({{(DividendW + 2 - PosW){1'b0}}, goal_q});
    quo_s   = $signed({2'b00, quotient});
    est     = opening ? (start_s - quo_s) : (start_s + quo_s);
    reached = opening ? (est <= goal_s) : (est >= goal_s);
    budget  = {1'b0, full_travel_q} + (endstop_q ? {1'b0, overshoot_q} : '0);
    halt    = (reached && !endstop_q)
           || (elapsed_q >= {{(ElapsedW - DivisorW - 1){1'b0}}, budget});
    if (est < 0) begin
      est_clamped = '0;
    end else if (est > $signed({{(DividendW + 2 - PosW){1'b0}}, PosMax})) begin
      est_clamped = PosMax;
    end else begin
      est_clamped = est[PosW-1:0];
    end
    new_pos = halt ? goal_q : est_clamped;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_xfer && op == OpTick && moving_q) state_d = StMul;
      end
      StMul: state_d = StDiv;
      StDiv: begin
        if (div_done) state_d = StFin;
      end
      StFin: begin
        if (out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      full_travel_q <= FullTravelRst;
      overshoot_q   <= OvershootRst;
      interval_q    <= IntervalRst;
      active_low_q  <= ActiveLowRst;
      moving_q      <= 1'b0;
      dir_q         <= MotionStop;
      start_q       <= '0;
      goal_q        <= '0;
      endstop_q     <= 1'b0;
      elapsed_q     <= '0;
      reported_q    <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_valid_i) begin
        unique case (reg_idx_e'(cfg_index_i))
          RegFullTravel: full_travel_q <= cfg_data_i;
          RegOvershoot:  overshoot_q   <= cfg_data_i;
          RegInterval:   interval_q    <= cfg_data_i[11:0];
          RegActiveLow:  active_low_q  <= cfg_data_i[0];
          default: ;
        endcase
      end

      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;

      if (in_xfer) begin
        unique case (op)
          OpMove: begin
            start_q   <= reported_q;
            goal_q    <= tgt_sat;
            endstop_q <= (tgt_sat == '0) || (tgt_sat == PosMax);
            elapsed_q <= '0;
            moving_q  <= 1'b1;
            dir_q     <= (tgt_sat < reported_q) ? MotionUp : MotionDown;
          end
          OpStop: begin
            moving_q <= 1'b0;
            dir_q    <= MotionStop;
          end
          OpTick: begin
            if (moving_q) elapsed_q <= elapsed_next;
          end
          default: ;
        endcase
        // a tick while moving reports later, from the finish step
        if (!(op == OpTick && moving_q)) out_valid_q <= 1'b1;
      end

      if (state_q == StFin && out_free) begin
        reported_q  <= new_pos;
        out_valid_q <= 1'b1;
        if (halt) begin
          moving_q <= 1'b0;
          dir_q    <= MotionStop;
        end
      end
    end
  end

  // result payload, loaded with the transfer of an item that completes at once, or from the finish step
  always_ff @(posedge clk_i) begin
    if (in_xfer && !(op == OpTick && moving_q)) begin
      out_pos_q <= reported_q;
      out_upd_q <= 1'b0;
      unique case (op)
        OpMove:  out_motion_q <= (tgt_sat < reported_q) ? MotionUp : MotionDown;
        OpStop:  out_motion_q <= MotionStop;
        default: out_motion_q <= dir_q;
      endcase
    end else if (state_q == StFin && out_free) begin
      out_pos_q    <= new_pos;
      out_upd_q    <= 1'b1;
      out_motion_q <= halt ? MotionStop : dir_q;
    end
  end

  // the user must rewrite polarity only while idle (the block does not enforce it), so it is safe to apply late
  assign out_valid_o        = out_valid_q;
  assign position_o         = out_pos_q;
  assign position_updated_o = out_upd_q;
  assign motion_state_o     = out_motion_q;
  assign relay_up_o         = (out_motion_q == MotionUp) ^ active_low_q;
  assign relay_down_o       = (out_motion_q == MotionDown) ^ active_low_q;

endmodule

/* tb/timed_cover_position_tracker_unit_tb.sv */
`timescale 1ns / 100ps

module timed_cover_position_tracker_unit_tb;
  import tcpt_pkg::*;

  // one report per command, in the shape of the result channel
  typedef struct packed {
    logic [PosW-1:0] position;
    logic            updated;
    logic            relay_up;
    logic            relay_down;
    motion_e         motion;
  } shade_report_t;

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_ni;

  // configuration write channel
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  // command channel
  logic            in_valid_i;
  logic            in_ready_o;
  logic [1:0]      operation_i;
  logic [PosW-1:0] target_position_i;

  // result channel
  logic            out_valid_o;
  logic            out_ready_i;
  logic [PosW-1:0] position_o;
  logic            position_updated_o;
  logic            relay_up_o;
  logic            relay_down_o;
  logic [1:0]      motion_state_o;

  // register copy, reset defaults
  logic [15:0] travel_ms       = FullTravelRst;
  logic [15:0] overshoot_ms    = OvershootRst;
  logic [11:0] tick_ms         = IntervalRst;
  logic        relays_inverted = ActiveLowRst;

  // shade state copy, stopped and fully open after reset
  logic            shade_moving = 1'b0;
  motion_e         shade_dir    = MotionStop;
  logic [PosW-1:0] run_from     = '0;
  logic [PosW-1:0] run_goal     = '0;
  logic            run_to_end   = 1'b0;
  logic [31:0]     run_ms       = '0;
  logic [PosW-1:0] shade_pos    = '0;

  shade_report_t expected_reports[$];
  int unsigned   mismatches    = 0;
  int unsigned   commands_sent = 0;
  int unsigned   sender_idle_pct = 0;
  int unsigned   ready_stall_pct = 0;

  timed_cover_position_tracker_unit u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .operation_i        (operation_i),
    .target_position_i  (target_position_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .position_o         (position_o),
    .position_updated_o (position_updated_o),
    .relay_up_o         (relay_up_o),
    .relay_down_o       (relay_down_o),
    .motion_state_o     (motion_state_o)
  );

  // 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // position estimate for one accepted command, report queued for the checker
  task automatic track_command(input op_e op, input logic [PosW-1:0] tgt);
    shade_report_t rep;
    logic [PosW-1:0] goal;
    logic fresh;
    logic opening;
    logic reached;
    longint acc;
    longint span;
    longint budget;
    longint from_l;
    longint goal_l;
    longint est;
    fresh = 1'b0;
    case (op)
      OpMove: begin
        // targets past the closed end saturate and become an end stop
        goal         = (tgt > PosMax) ? PosMax : tgt;
        run_from     = shade_pos;
        run_goal     = goal;
        run_to_end   = (goal == '0) || (goal == PosMax);
        run_ms       = '0;
        shade_moving = 1'b1;
        shade_dir    = (goal < shade_pos) ? MotionUp : MotionDown;
      end
      OpStop: begin
        shade_moving = 1'b0;
        shade_dir    = MotionStop;
      end
      OpTick: begin
        // a tick while stopped leaves everything alone
        if (shade_moving) begin
          fresh = 1'b1;
          acc = run_ms;
          acc = acc + tick_ms;
          run_ms = (acc > 64'sh0_FFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
          // zero travel time divides by one
          span = (travel_ms == '0) ? 1 : travel_ms;
          budget = travel_ms;
          if (run_to_end) begin
            budget = budget + overshoot_ms;
          end
          from_l = run_from;
          goal_l = run_goal;
          acc = run_ms;
          // signed quotient, truncated towards zero
          est = from_l + ((goal_l - from_l) * acc) / span;
          opening = run_goal < run_from;
          reached = opening ? (est <= goal_l) : (est >= goal_l);
          if ((reached && !run_to_end) || acc >= budget) begin
            shade_pos    = run_goal;
            shade_moving = 1'b0;
            shade_dir    = MotionStop;
          end else begin
            if (est < 0) est = 0;
            if (est > PosMax) est = PosMax;
            shade_pos = est[PosW-1:0];
          end
        end
      end
      default: ;
    endcase
    rep.position   = shade_pos;
    rep.updated    = fresh;
    rep.relay_up   = (shade_dir == MotionUp) ^ relays_inverted;
    rep.relay_down = (shade_dir == MotionDown) ^ relays_inverted;
    rep.motion     = shade_dir;
    expected_reports.push_back(rep);
  endtask

  // one command transfer; valid is left high so the next command can follow at once
  task automatic send_command(input op_e op, input logic [PosW-1:0] tgt);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    operation_i       <= op;
    target_position_i <= tgt;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    track_command(op, tgt);
    commands_sent++;
  endtask

  // drop valid and wait until every report is back
  task automatic settle_idle();
    in_valid_i <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // all four registers back to back, only while the block is idle
  task automatic program_registers(input logic [15:0] trav, input logic [15:0] over,
                                   input logic [15:0] intv, input logic [15:0] alow);
    logic [15:0] vals[4];
    vals = '{trav, over, intv, alow};
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= reg_idx_e'(i);
      cfg_data_i  <= vals[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      case (reg_idx_e'(i))
        RegFullTravel: travel_ms       = vals[i];
        RegOvershoot:  overshoot_ms    = vals[i];
        RegInterval:   tick_ms         = vals[i][11:0];
        RegActiveLow:  relays_inverted = vals[i][0];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  // move, then ticks until the shade stops or the tick budget runs out
  task automatic drive_traverse(input logic [PosW-1:0] tgt, input int unsigned max_ticks,
                                input logic may_halt);
    int unsigned n;
    send_command(OpMove, tgt);
    n = 0;
    while (shade_moving && n < max_ticks) begin
      send_command(OpTick, '0);
      n++;
    end
    // sometimes cut the run short, otherwise the next move re-targets mid-flight
    if (shade_moving && may_halt && $urandom_range(0, 9) < 3) begin
      send_command(OpStop, PosW'($urandom_range(0, 16383)));
    end
  endtask

  // end stops, re-targeting to the present position, out of range, ordinary goals
  function automatic logic [PosW-1:0] pick_goal();
    case ($urandom_range(0, 9))
      0, 1:    return '0;
      2, 3:    return PosMax;
      4:       return shade_pos;
      5:       return PosW'($urandom_range(10001, 16383));
      default: return PosW'($urandom_range(1, 9999));
    endcase
  endfunction

  // check each result transfer against the oldest queued report
  always @(posedge clk_i) begin
    shade_report_t want;
    logic orphan;
    if (rst_ni) begin
      out_ready_i <= ($urandom_range(0, 99) >= ready_stall_pct);
      if (out_valid_o && out_ready_i) begin
        orphan = (expected_reports.size() == 0);
        want   = orphan ? '0 : expected_reports.pop_front();
        if (orphan || position_o !== want.position || position_updated_o !== want.updated ||
            relay_up_o !== want.relay_up || relay_down_o !== want.relay_down ||
            motion_state_o !== want.motion) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t %s: exp pos %0d upd %0b up %0b dn %0b mot %0d, got pos %0d upd %0b up %0b dn %0b mot %0d",
                     $realtime, orphan ? "unexpected result" : "result mismatch",
                     want.position, want.updated, want.relay_up, want.relay_down, want.motion,
                     position_o, position_updated_o, relay_up_o, relay_down_o, motion_state_o);
          end
        end
      end
    end
  end

  // reset values: default timing and active-low relays
  task automatic test_reset_defaults();
    send_command(OpMove, 14'd5000);
    send_command(OpTick, '0);
    send_command(OpStop, '0);
  endtask

  // every command, end stops, early arrival, goal at the start, idle paths
  task automatic test_directed_commands();
    settle_idle();
    program_registers(16'd1000, 16'd400, 16'd250, 16'd0);
    drive_traverse(14'h3FFF, 20, 1'b0);
    drive_traverse(14'd3000, 20, 1'b0);
    drive_traverse(14'd3000, 20, 1'b0);
    send_command(OpMove, '0);
    send_command(OpTick, '0);
    send_command(OpTick, '0);
    send_command(OpStop, 14'h3FFF);
    send_command(OpTick, '0);
    send_command(OpNone, 14'h2AAA);
  endtask

  // zero travel time, zero tick interval, widest registers, both relay polarities
  task automatic test_register_extremes();
    settle_idle();
    program_registers(16'd0, 16'd0, 16'h0FFF, 16'h0001);
    drive_traverse(14'd7000, 4, 1'b0);
    settle_idle();
    program_registers(16'hFFFF, 16'hFFFF, 16'hF000, 16'hFFFE);
    send_command(OpMove, PosMax);
    repeat (3) send_command(OpTick, '0);
    send_command(OpStop, '0);
  endtask

  // random traverses and noise under one idling pattern, random then extreme registers
  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input int unsigned corner, input int unsigned count);
    logic [15:0] trav;
    logic [15:0] intv;
    int unsigned goal_cnt;
    settle_idle();
    sender_idle_pct = idle_pct;
    ready_stall_pct = stall_pct;
    for (int half = 0; half < 2; half++) begin
      settle_idle();
      if (half == 0) begin
        // keep full traverses to a few dozen ticks
        trav = 16'($urandom_range(1, 8000));
        intv = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 4095))
                                           : 16'(trav / $urandom_range(2, 40));
        if (intv[11:0] == '0) intv = 16'd1;
        program_registers(trav, 16'($urandom_range(0, trav)),
                          {4'($urandom_range(0, 15)), intv[11:0]},
                          16'($urandom_range(0, 65535)));
      end else begin
        case (corner)
          0:       program_registers(16'hFFFF, 16'hFFFF, 16'h0FFF, 16'h0000);
          1:       program_registers(16'h0001, 16'h0000, 16'h0001, 16'h0001);
          2:       program_registers(16'hFFFF, 16'h0000, 16'h0FFF, 16'h0001);
          default: program_registers(16'h0001, 16'hFFFF, 16'h0FFF, 16'h0000);
        endcase
      end
      goal_cnt = commands_sent + count / 2;
      while (commands_sent < goal_cnt) begin
        if ($urandom_range(0, 99) < 85) begin
          drive_traverse(pick_goal(), $urandom_range(1, 60), 1'b1);
        end else begin
          send_command(op_e'($urandom_range(0, 3)), PosW'($urandom_range(0, 16383)));
        end
      end
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_index_i       = '0;
    cfg_data_i        = '0;
    in_valid_i        = 1'b0;
    operation_i       = '0;
    target_position_i = '0;
    out_ready_i       = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_directed_commands();
    test_register_extremes();
    test_random_traffic(0, 0, 0, 450);
    test_random_traffic(78, 0, 1, 450);
    test_random_traffic(0, 78, 2, 450);
    test_random_traffic(18, 18, 3, 450);

    // drain, then keep watching for anything stray before the verdict
    settle_idle();
    repeat (60) @(posedge clk_i);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("timed_cover_position_tracker_unit_tb: done, clean");
    end else begin
      $display("timed_cover_position_tracker_unit_tb: done, errors");
    end
    $finish;
  end

  // watchdog, in case the run hangs
  initial begin
    #4_000_000;
    $display("timed_cover_position_tracker_unit_tb: done, errors");
    $finish;
  end

endmodule
